/* rtl/core/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and codes of the randomized set: transaction structs,
// operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int DRAW_W = 16;
    localparam int STEP_W = $clog2(DRAW_W + 1);

    // Operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_RANDOM = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
        logic [DRAW_W-1:0]        random_draw;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] picked_value;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/rss_mem.sv */
// ----------------------------------------------------------------------------
// rss_mem
// Member store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_mem #(
    parameter int DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_we,
    input  wire  [$clog2(DEPTH)-1:0]            i_waddr,
    input  wire  signed [rss_pkg::DATA_W-1:0]   i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]            i_raddr,
    output logic signed [rss_pkg::DATA_W-1:0]   o_rdata
);

    logic signed [rss_pkg::DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/rss_mod.sv */
// ----------------------------------------------------------------------------
// rss_mod
// Bit-serial restoring remainder: draw mod count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_mod #(
    parameter int CNT_W = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [rss_pkg::DRAW_W-1:0]   i_dividend,
    input  wire  [CNT_W-1:0]             i_divisor,
    output logic                         o_done,
    output logic [CNT_W-1:0]             o_rem
);

    logic                         r_run;
    logic [rss_pkg::STEP_W-1:0]   r_cnt;
    logic [rss_pkg::DRAW_W-1:0]   r_dvd;
    logic [CNT_W-1:0]             r_div;
    logic [CNT_W-1:0]             r_rem;
    logic                         r_done;
    logic [CNT_W:0]               trial;
    logic [CNT_W:0]               diff;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[rss_pkg::DRAW_W-1]};
    assign diff  = trial - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= rss_pkg::STEP_W'(rss_pkg::DRAW_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rss_pkg::STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[rss_pkg::DRAW_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[CNT_W-1:0];
            end else begin
                r_rem <= trial[CNT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/core/randomized_set_swap_remove_top.sv */
// ----------------------------------------------------------------------------
// randomized_set_swap_remove_top
// Set of distinct 32-bit values in a dense store: insert, swap-remove and
// random pick, sequenced over one synchronous memory.
// Steps: insert scans the entries; remove scans, then reads the last entry and
//   writes it into the freed slot; get random runs the 16-step remainder unit,
//   then reads the picked entry; empty-set pick and unused code finish from idle.
// Throughput: one transaction at a time, one stored entry scanned per cycle.
// Reset: synchronous, clears the member count and control; store contents
//   stay undefined, no clearing pass. Results are strobed, never stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_set_swap_remove_top #(
    parameter int CAPACITY = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire  rss_pkg::t_item      i_item,
    output logic                      o_done,
    output rss_pkg::t_result          o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_LAST  = 6'b000100,
        S_LASTW = 6'b001000,
        S_MOD   = 6'b010000,
        S_PICKW = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_issue, n_issue;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [IW-1:0] r_pos, n_pos;
    logic [1:0]    r_func, n_func;
    logic signed [rss_pkg::DATA_W-1:0] r_val, n_val;
    logic             r_done, n_done;
    rss_pkg::t_result r_res, n_res;

    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    logic signed [rss_pkg::DATA_W-1:0] mem_wdata;
    logic [IW-1:0]                     mem_raddr;
    logic signed [rss_pkg::DATA_W-1:0] mem_rdata;

    logic          mod_start;
    logic          mod_done;
    logic [CW-1:0] mod_rem;
    logic          hit;

    // Member store
    rss_mem #(.DEPTH(CAPACITY)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Remainder unit for the random pick
    rss_mod #(.CNT_W(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_item.random_draw),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign hit       = r_pend && (mem_rdata == r_val);
    assign mod_start = (r_state == S_IDLE) && start && (i_item.func == rss_pkg::FN_RANDOM)
                       && (r_count != '0);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_pos      = r_pos;
        n_func     = r_func;
        n_val      = r_val;
        n_done     = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_count[IW-1:0];
        mem_wdata  = r_val;
        mem_raddr  = r_issue[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val  = i_item.value;
                    n_func = i_item.func;
                    n_res.picked_value = '0;
                    priority if (i_item.func == rss_pkg::FN_INSERT ||
                                 i_item.func == rss_pkg::FN_REMOVE) begin
                        n_issue = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else if (i_item.func == rss_pkg::FN_RANDOM) begin
                        if (r_count == '0) begin
                            n_done       = 1'b1;
                            n_res.status = rss_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_MOD;
                        end
                    end else begin
                        n_done       = 1'b1;
                        n_res.status = rss_pkg::ST_REJECT;
                    end
                end
            end

            // Walk the occupied entries, compare one per cycle
            S_SCAN: begin
                n_res.picked_value = '0;
                priority if (hit) begin
                    if (r_func == rss_pkg::FN_INSERT) begin
                        n_done       = 1'b1;
                        n_res.status = rss_pkg::ST_REJECT;
                        n_state      = S_IDLE;
                    end else begin
                        n_pos   = r_pend_idx;
                        n_state = S_LAST;
                    end
                end else if (r_issue < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IW-1:0];
                    n_issue    = r_issue + 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    // Value absent
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    priority if (r_func == rss_pkg::FN_REMOVE) begin
                        n_res.status = rss_pkg::ST_REJECT;
                    end else if (r_count == CAP_C) begin
                        n_res.status = rss_pkg::ST_FULL;
                    end else begin
                        mem_we       = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_res.status = rss_pkg::ST_DONE;
                    end
                end
            end

            // Fetch the last occupied entry
            S_LAST: begin
                mem_raddr = IW'(r_count - 1'b1);
                n_state   = S_LASTW;
            end

            // Move it into the freed slot
            S_LASTW: begin
                mem_we       = 1'b1;
                mem_waddr    = r_pos;
                mem_wdata    = mem_rdata;
                n_count      = r_count - 1'b1;
                n_done       = 1'b1;
                n_res.status = rss_pkg::ST_DONE;
                n_state      = S_IDLE;
            end

            // Wait for the remainder, then read that entry
            S_MOD: begin
                mem_raddr = mod_rem[IW-1:0];
                if (mod_done) begin
                    n_state = S_PICKW;
                end
            end

            S_PICKW: begin
                n_done             = 1'b1;
                n_res.status       = rss_pkg::ST_DONE;
                n_res.picked_value = mem_rdata;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_pos      <= n_pos;
        r_func     <= n_func;
        r_val      <= n_val;
        r_res      <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("member count above capacity");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SCAN || r_state == S_LASTW))
        else $error("store write outside an update step");

    a_count_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(mem_we))
        else $error("count changed without a store write");

    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("remainder finished outside pick");

    a_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != rss_pkg::ST_DONE) |-> (o_result.picked_value == '0))
        else $error("nonzero pick on a failed transaction");

endmodule

`default_nettype wire
